// File: src/sktbl_pkg.sv
// shared types and codes for the sorted key record table
package sktbl_pkg;

   // operation codes of a request
   localparam logic [1:0] KIND_UPSERT = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_FOUND  = 2'd0;
   localparam logic [1:0] STATUS_ABSENT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic [31:0] due_day;
      logic [15:0] interval;
      logic [15:0] easiness;
      logic [7:0]  reps;
      logic [7:0]  lapses;
      logic [7:0]  grade;
   } rec_type;

   typedef struct packed {
      logic [31:0] key;
      rec_type     rec;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SEARCH = 7'b0000010,
      S_PROBE  = 7'b0000100,
      S_CHECK  = 7'b0001000,
      S_SHIFT  = 7'b0010000,
      S_INSERT = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

endpackage

// File: src/sktbl_ram.sv
// generic single write port, single read port ram with registered read
module sktbl_ram #(
   parameter int WIDTH = 120,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sorted_key_record_table_top.sv
// top level of the sorted key record table: sequencer, search and shift control
//
// Keeps up to CAPACITY schedule records in one RAM, sorted strictly ascending by
// card_id. Every transaction is handled alone; req_ready is high only while the
// sequencer is idle, and a new request may be taken while the previous response
// still waits in the output register. The RAM has one read and one write port
// with registered read, and that port sets the timing. Each binary search probe
// issues a read in S_SEARCH and compares the row in S_PROBE, and S_SEARCH ends
// the search once lo meets hi. S_CHECK then checks the final position when it
// lies inside the table. A lookup or an update of an existing key passes through
// S_IDLE, the search, S_CHECK and S_FINISH. An insert moves each record above
// the position up one place in S_SHIFT and then writes the new record in
// S_INSERT. A clear goes straight from S_IDLE to S_FINISH. The response cycle
// waits while the output register still holds an unaccepted response. The table
// contents need no clearing after reset: the record count alone marks which
// rows are live. Inserts that miss on a full table are dropped with status 2.
module sorted_key_record_table_top #(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_card_id,
   input  logic [31:0] req_due_day,
   input  logic [15:0] req_interval_days,
   input  logic [15:0] req_easiness_milli,
   input  logic [7:0]  req_reps,
   input  logic [7:0]  req_lapses,
   input  logic [7:0]  req_last_grade,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_due_day,
   output logic [15:0] rsp_found_interval,
   output logic [15:0] rsp_found_easiness,
   output logic [7:0]  rsp_found_reps,
   output logic [7:0]  rsp_found_lapses,
   output logic [7:0]  rsp_found_grade,
   output logic [8:0]  rsp_entry_count
);

   import sktbl_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] src_ff, src_in;
   logic [1:0]       status_ff, status_in;
   rec_type          rec_ff, rec_in;
   logic [1:0]       kind_ff, kind_in;
   row_type          req_row_ff, req_row_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   rec_type          rsp_rec_ff, rsp_rec_in;
   logic [8:0]       rsp_count_ff, rsp_count_in;

   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   row_type          rd_row, wr_row;
   logic [ROW_W-1:0] rd_data;

   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] fill_dec;
   logic [CNT_W+8:0] fill_ext;
   logic             miss_go;

   sktbl_ram #(
      .WIDTH(ROW_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_row),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_row   = row_type'(rd_data);
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign fill_dec = fill_ff - CNT_W'(1);
   assign fill_ext = {9'd0, fill_in};

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      src_in        = src_ff;
      status_in     = status_ff;
      rec_in        = rec_ff;
      kind_in       = kind_ff;
      req_row_in    = req_row_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_row        = req_row_ff;
      miss_go       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in                 = req_kind;
               req_row_in.key          = req_card_id;
               req_row_in.rec.due_day  = req_due_day;
               req_row_in.rec.interval = req_interval_days;
               req_row_in.rec.easiness = req_easiness_milli;
               req_row_in.rec.reps     = req_reps;
               req_row_in.rec.lapses   = req_lapses;
               req_row_in.rec.grade    = req_last_grade;
               if (req_kind == KIND_CLEAR) begin
                  fill_in   = '0;
                  status_in = STATUS_FOUND;
                  rec_in    = '0;
                  state_in  = S_FINISH;
               end else begin
                  lo_in    = '0;
                  hi_in    = fill_ff;
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid[IDX_W-1:0];
               state_in = S_PROBE;
            end else if (lo_ff < fill_ff) begin
               rd_en    = 1'b1;
               rd_addr  = lo_ff[IDX_W-1:0];
               state_in = S_CHECK;
            end else begin
               miss_go = 1'b1;
            end
         end
         S_PROBE: begin
            // the probed row was read at mid, which still holds
            if (rd_row.key < req_row_ff.key) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            state_in = S_SEARCH;
         end
         S_CHECK: begin
            if (rd_row.key == req_row_ff.key) begin
               status_in = STATUS_FOUND;
               state_in  = S_FINISH;
               if (kind_ff == KIND_UPSERT) begin
                  wr_en   = 1'b1;
                  wr_addr = lo_ff[IDX_W-1:0];
                  rec_in  = req_row_ff.rec;
               end else begin
                  rec_in = rd_row.rec;
               end
            end else begin
               miss_go = 1'b1;
            end
         end
         S_SHIFT: begin
            // move the row read last cycle up one place, read the next one down
            wr_en   = 1'b1;
            wr_addr = src_ff + IDX_W'(1);
            wr_row  = rd_row;
            if (CNT_W'(src_ff) > lo_ff) begin
               rd_en   = 1'b1;
               rd_addr = src_ff - IDX_W'(1);
               src_in  = src_ff - IDX_W'(1);
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            wr_en     = 1'b1;
            wr_addr   = lo_ff[IDX_W-1:0];
            fill_in   = fill_ff + CNT_W'(1);
            status_in = STATUS_ABSENT;
            rec_in    = req_row_ff.rec;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_rec_in    = rec_ff;
               rsp_count_in  = fill_ext[8:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (miss_go) begin
         if (kind_ff == KIND_UPSERT) begin
            if (fill_ff == CAP_CNT) begin
               status_in = STATUS_FULL;
               rec_in    = '0;
               state_in  = S_FINISH;
            end else if (fill_ff > lo_ff) begin
               rd_en    = 1'b1;
               rd_addr  = fill_dec[IDX_W-1:0];
               src_in   = fill_dec[IDX_W-1:0];
               state_in = S_SHIFT;
            end else begin
               state_in = S_INSERT;
            end
         end else begin
            status_in = STATUS_ABSENT;
            rec_in    = '0;
            state_in  = S_FINISH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      src_ff        <= src_in;
      status_ff     <= status_in;
      rec_ff        <= rec_in;
      kind_ff       <= kind_in;
      req_row_ff    <= req_row_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_due_day  = rsp_rec_ff.due_day;
   assign rsp_found_interval = rsp_rec_ff.interval;
   assign rsp_found_easiness = rsp_rec_ff.easiness;
   assign rsp_found_reps     = rsp_rec_ff.reps;
   assign rsp_found_lapses   = rsp_rec_ff.lapses;
   assign rsp_found_grade    = rsp_rec_ff.grade;
   assign rsp_entry_count    = rsp_count_ff;

endmodule
